/* rtl/quadtree_polynomial_hash_top_macros.svh */
// Assertion macros shared by the quadtree hash RTL.
`ifndef QUADTREE_POLYNOMIAL_HASH_TOP_MACROS_SVH
`define QUADTREE_POLYNOMIAL_HASH_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define QPH_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication with a delay set by n, disabled while reset is high.
`define QPH_ASSERT_DELAY(label, clk, rst, ante, n, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error(msg);

`endif

/* rtl/qph_pkg.sv */
// Constants, types and constant tables of the quadtree polynomial hash.
package qph_pkg;

   localparam int MAX_DEPTH = 256;
   localparam int ROM_IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int HASH_W    = 30;
   localparam int DEPTH_W   = 8;
   localparam int SUM_W     = 62;

   typedef logic [HASH_W-1:0] hash_type;
   typedef logic [MAX_DEPTH-1:0][HASH_W-1:0] pow_rom_type;
   typedef logic [15:0][HASH_W-1:0] leaf_rom_type;

   typedef enum logic {
      OP_LEAF = 1'b0,
      OP_NODE = 1'b1
   } opcode_type;

   localparam logic [63:0] P64        = 64'd1000000007;
   localparam hash_type    HASH_PRIME = 30'd1000000007;
   localparam hash_type    X_MUL      = 30'd2331;
   localparam hash_type    Y_MUL      = 30'd121212121;

   // 2^31 mod P, used to fold the upper bits of the sum back down.
   localparam logic [27:0] FOLD_C    = 28'((64'd1 << 31) % P64);
   // Barrett reciprocal floor(2^60 / P).
   localparam logic [30:0] BARRETT_M = 31'((64'd1 << 60) / P64);

   function automatic hash_type mul_mod(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] prod;
      prod = a * b;
      return HASH_W'(prod % P64);
   endfunction

   // Entry d holds base^(2 * 2^d) mod P.
   function automatic pow_rom_type build_pow_rom(input hash_type base);
      pow_rom_type rom;
      hash_type    v;
      v = mul_mod(64'(base), 64'(base));
      for (int d = 0; d < MAX_DEPTH; d++) begin
         rom[d] = v;
         v      = mul_mod(64'(v), 64'(v));
      end
      return rom;
   endfunction

   localparam pow_rom_type X_POW_ROM = build_pow_rom(X_MUL);
   localparam pow_rom_type Y_POW_ROM = build_pow_rom(Y_MUL);

   function automatic pow_rom_type build_xy_rom();
      pow_rom_type rom;
      for (int d = 0; d < MAX_DEPTH; d++) begin
         rom[d] = mul_mod(64'(X_POW_ROM[d]), 64'(Y_POW_ROM[d]));
      end
      return rom;
   endfunction

   localparam pow_rom_type XY_POW_ROM = build_xy_rom();

   function automatic leaf_rom_type build_leaf_rom();
      leaf_rom_type rom;
      logic [63:0]  xy;
      logic [63:0]  acc;
      logic [3:0]   cells;
      xy = 64'(mul_mod(64'(X_MUL), 64'(Y_MUL)));
      for (int c = 0; c < 16; c++) begin
         cells  = 4'(c);
         acc    = (cells[0] ? 64'd2 : 64'd1)
                + (cells[1] ? 64'd2 : 64'd1) * 64'(X_MUL)
                + (cells[2] ? 64'd2 : 64'd1) * 64'(Y_MUL)
                + (cells[3] ? 64'd2 : 64'd1) * xy;
         rom[c] = HASH_W'(acc % P64);
      end
      return rom;
   endfunction

   localparam leaf_rom_type LEAF_ROM = build_leaf_rom();

endpackage

/* rtl/qph_mod_reduce.sv */
// Pipelined reduction of a 62-bit sum modulo the hash prime.
`include "quadtree_polynomial_hash_top_macros.svh"

module qph_mod_reduce (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [61:0]      in_sum,
   output logic             out_valid,
   output qph_pkg::hash_type out_residue
);
   import qph_pkg::*;

   localparam logic [31:0] P32     = 32'(P64);
   localparam logic [31:0] TWO_P32 = 32'(2 * P64);

   logic [59:0] fold_ff, fold_in;
   logic        fold_valid_ff;
   logic [58:0] fold_prod;

   logic [30:0] quot_ff, quot_in;
   logic [31:0] low_ff;
   logic        quot_valid_ff;
   logic [61:0] quot_prod;

   logic [31:0] rem_ff, rem_in;
   logic        rem_valid_ff;
   logic [31:0] qp_low;

   hash_type    res_ff, res_in;
   logic        res_valid_ff;

   // Stage A: fold bits 61..31 back in with weight 2^31 mod P; the result stays below 2^60.
   assign fold_prod = 59'(in_sum[61:31]) * 59'(FOLD_C);
   assign fold_in   = 60'(fold_prod) + 60'(in_sum[30:0]);

   // Stage B: Barrett quotient estimate, at most two below the true quotient.
   assign quot_prod = 62'(fold_ff[59:29]) * 62'(BARRETT_M);
   assign quot_in   = quot_prod[61:31];

   // Stage C: the remainder is below 3P, so 32 bits of the difference are exact.
   assign qp_low = 32'(quot_ff) * P32;
   assign rem_in = low_ff - qp_low;

   // Stage D: final correction.
   always_comb begin
      if (rem_ff >= TWO_P32) begin
         res_in = HASH_W'(rem_ff - TWO_P32);
      end else if (rem_ff >= P32) begin
         res_in = HASH_W'(rem_ff - P32);
      end else begin
         res_in = HASH_W'(rem_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
         quot_valid_ff <= 1'b0;
         rem_valid_ff  <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         fold_valid_ff <= in_valid;
         quot_valid_ff <= fold_valid_ff;
         rem_valid_ff  <= quot_valid_ff;
         res_valid_ff  <= rem_valid_ff;
      end
      fold_ff <= fold_in;
      quot_ff <= quot_in;
      low_ff  <= fold_ff[31:0];
      rem_ff  <= rem_in;
      res_ff  <= res_in;
   end

   assign out_valid   = res_valid_ff;
   assign out_residue = res_ff;

   `QPH_ASSERT_IMPLY(a_rem_bound, clock, reset, rem_valid_ff, rem_ff < 32'(3 * P64), "remainder estimate not below 3P")
   `QPH_ASSERT_IMPLY(a_res_bound, clock, reset, res_valid_ff, res_ff < HASH_PRIME, "residue not below P")
   `QPH_ASSERT_DELAY(a_latency, clock, reset, in_valid, 4, out_valid, "reduction lost a request")

endmodule

/* rtl/quadtree_polynomial_hash_top.sv */
// Quadtree block hash: leaf and node hashing modulo 1000000007, seven-stage pipeline.
// A request is accepted at every edge with req_start high; busy is always low.
// The result strobes rsp_valid once it has passed the stage registers and the reduction pipeline.
// Throughput: one request per cycle, set by the fully pipelined multipliers and reduction.
// Reset clears the pipeline valid bits only; the power and leaf tables are constant.
`include "quadtree_polynomial_hash_top_macros.svh"

module quadtree_polynomial_hash_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_start,
   output logic                    busy,
   input  logic                    req_opcode,
   input  logic [3:0]              req_leaf_cells,
   input  qph_pkg::hash_type       req_child_nw_hash,
   input  qph_pkg::hash_type       req_child_ne_hash,
   input  qph_pkg::hash_type       req_child_sw_hash,
   input  qph_pkg::hash_type       req_child_se_hash,
   input  logic [qph_pkg::DEPTH_W-1:0] req_child_depth,
   output logic                    rsp_valid,
   output qph_pkg::hash_type       rsp_block_hash
);
   import qph_pkg::*;

   logic                 req_accept;
   logic [ROM_IDX_W-1:0] rom_idx;
   logic                 node_op;

   // Stage 1: table lookups and operand selection.
   logic     s1_valid_ff;
   hash_type xp_ff, yp_ff, xyp_ff;
   hash_type nw_ff, ne_ff, sw_ff, se_ff;
   hash_type nw_in, ne_in, sw_in, se_in;

   // Stage 2: products.
   logic        s2_valid_ff;
   logic [59:0] p_ne_ff, p_sw_ff, p_se_ff;
   hash_type    nw2_ff;

   // Stage 3: sum, below 2^62.
   logic        s3_valid_ff;
   logic [61:0] sum_ff, sum_in;

   assign busy       = 1'b0;
   assign req_accept = req_start && !busy;
   assign node_op    = (opcode_type'(req_opcode) == OP_NODE);

   // Depths past the table reuse its last entry.
   always_comb begin
      if ({1'b0, req_child_depth} >= 9'(MAX_DEPTH)) begin
         rom_idx = ROM_IDX_W'(MAX_DEPTH - 1);
      end else begin
         rom_idx = req_child_depth[ROM_IDX_W-1:0];
      end
   end

   // A leaf request rides the same datapath with the other children zeroed.
   always_comb begin
      if (node_op) begin
         nw_in = req_child_nw_hash;
         ne_in = req_child_ne_hash;
         sw_in = req_child_sw_hash;
         se_in = req_child_se_hash;
      end else begin
         nw_in = LEAF_ROM[req_leaf_cells];
         ne_in = '0;
         sw_in = '0;
         se_in = '0;
      end
   end

   assign sum_in = 62'(nw2_ff) + 62'(p_ne_ff) + 62'(p_sw_ff) + 62'(p_se_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      xp_ff   <= X_POW_ROM[rom_idx];
      yp_ff   <= Y_POW_ROM[rom_idx];
      xyp_ff  <= XY_POW_ROM[rom_idx];
      nw_ff   <= nw_in;
      ne_ff   <= ne_in;
      sw_ff   <= sw_in;
      se_ff   <= se_in;
      p_ne_ff <= 60'(xp_ff) * 60'(ne_ff);
      p_sw_ff <= 60'(yp_ff) * 60'(sw_ff);
      p_se_ff <= 60'(xyp_ff) * 60'(se_ff);
      nw2_ff  <= nw_ff;
      sum_ff  <= sum_in;
   end

   qph_mod_reduce u_reduce (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s3_valid_ff),
      .in_sum      (sum_ff),
      .out_valid   (rsp_valid),
      .out_residue (rsp_block_hash)
   );

   `QPH_ASSERT_DELAY(a_req_to_rsp, clock, reset, req_accept, 7, rsp_valid, "request produced no response")
   `QPH_ASSERT_IMPLY(a_rsp_has_req, clock, reset, rsp_valid, $past(req_accept, 7), "response without a request")
   `QPH_ASSERT_DELAY(a_leaf_value, clock, reset, req_accept && !node_op, 7, rsp_block_hash == LEAF_ROM[$past(req_leaf_cells, 7)], "leaf hash mismatch")

endmodule

/* tb/quadtree_polynomial_hash_top_test.sv */
// Self-checking testbench for the quadtree polynomial hash block.
module quadtree_polynomial_hash_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import qph_pkg::*;

   localparam logic [63:0] PRIME       = 64'd1000000007;
   localparam logic [63:0] COL_MUL     = 64'd2331;
   localparam logic [63:0] ROW_MUL     = 64'd121212121;
   localparam hash_type    HASH_MAX    = 30'h3fff_ffff;
   localparam int          DEPTHS      = 256;
   localparam int          DIRECTED    = 24;
   localparam int          RANDOM_REQS = 600;
   localparam int          DRAIN_WAIT  = 12;
   localparam int          STALL_LIMIT = 2000;

   typedef struct {
      opcode_type  op;
      logic [3:0]  cells;
      hash_type    nw;
      hash_type    ne;
      hash_type    sw;
      hash_type    se;
      logic [7:0]  depth;
      bit          has_typed;
      hash_type    typed_hash;
   } hash_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_start = 1'b0;
   logic        busy;
   logic        req_opcode = 1'b0;
   logic [3:0]  req_leaf_cells = 4'h0;
   hash_type    req_child_nw_hash = '0;
   hash_type    req_child_ne_hash = '0;
   hash_type    req_child_sw_hash = '0;
   hash_type    req_child_se_hash = '0;
   logic [7:0]  req_child_depth = 8'd0;
   logic        rsp_valid;
   hash_type    rsp_block_hash;

   // Typed expectation that travels with the request currently on the ports.
   bit          cur_has_typed = 1'b0;
   hash_type    cur_typed_hash = '0;

   logic [63:0]      col_pow_by_depth [DEPTHS];
   logic [63:0]      row_pow_by_depth [DEPTHS];
   hash_type         expected_hashes [$];
   hash_request_type directed_rows [DIRECTED];

   int mismatch_count = 0;
   int compared_count = 0;
   int leaf_count = 0;
   int node_count = 0;
   int stall_cycles = 0;
   int burst_left = 0;

   quadtree_polynomial_hash_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_start         (req_start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_leaf_cells    (req_leaf_cells),
      .req_child_nw_hash (req_child_nw_hash),
      .req_child_ne_hash (req_child_ne_hash),
      .req_child_sw_hash (req_child_sw_hash),
      .req_child_se_hash (req_child_se_hash),
      .req_child_depth   (req_child_depth),
      .rsp_valid         (rsp_valid),
      .rsp_block_hash    (rsp_block_hash)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] mul_mod_prime(input logic [63:0] a, input logic [63:0] b);
      return (a * b) % PRIME;
   endfunction

   function automatic hash_type predict_block_hash(input logic op, input logic [3:0] cells,
                                                   input hash_type nw, input hash_type ne,
                                                   input hash_type sw, input hash_type se,
                                                   input logic [7:0] depth);
      logic [63:0] diag;
      logic [63:0] sum;
      if (op == OP_LEAF) begin
         diag = mul_mod_prime(COL_MUL, ROW_MUL);
         sum  = (cells[0] ? 64'd2 : 64'd1)
              + (cells[1] ? 64'd2 : 64'd1) * COL_MUL
              + (cells[2] ? 64'd2 : 64'd1) * ROW_MUL
              + (cells[3] ? 64'd2 : 64'd1) * diag;
      end else begin
         // Child hashes at or above the prime are summed as they are; the
         // final reduction folds them to their residue.
         diag = mul_mod_prime(col_pow_by_depth[depth], row_pow_by_depth[depth]);
         sum  = 64'(nw) + col_pow_by_depth[depth] * 64'(ne)
              + row_pow_by_depth[depth] * 64'(sw) + diag * 64'(se);
      end
      return hash_type'(sum % PRIME);
   endfunction

   function automatic hash_type random_child_hash();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return hash_type'(PRIME - 1);
         2, 3:    return hash_type'($urandom_range(HASH_MAX, 32'(PRIME)));
         default: return hash_type'($urandom_range(32'(PRIME) - 1, 0));
      endcase
   endfunction

   task automatic issue_request(input hash_request_type r);
      int gap;
      gap = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else if ($urandom_range(0, 15) == 0) begin
         burst_left = $urandom_range(10, 40);
      end else begin
         case ($urandom_range(0, 19))
            0, 1:    gap = $urandom_range(10, 40);
            2, 3, 4, 5, 6, 7, 8, 9: gap = $urandom_range(1, 3);
            default: gap = 0;
         endcase
      end
      if (gap > 0) begin
         req_start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_start         <= 1'b1;
      req_opcode        <= r.op;
      req_leaf_cells    <= r.cells;
      req_child_nw_hash <= r.nw;
      req_child_ne_hash <= r.ne;
      req_child_sw_hash <= r.sw;
      req_child_se_hash <= r.se;
      req_child_depth   <= r.depth;
      cur_has_typed     <= r.has_typed;
      cur_typed_hash    <= r.typed_hash;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Compare each strobed hash with the oldest expectation, then record the
   // expectation of any request taken at this edge.
   always @(posedge clock) begin : scoreboard
      hash_type expected_hash;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_hashes.size() == 0) begin
               $display("%0t: unexpected block_hash %0d with no request outstanding",
                        $time, rsp_block_hash);
               mismatch_count++;
            end else begin
               expected_hash = expected_hashes.pop_front();
               compared_count++;
               if (rsp_block_hash !== expected_hash) begin
                  $display("%0t: block_hash mismatch, expected %0d, got %0d",
                           $time, expected_hash, rsp_block_hash);
                  mismatch_count++;
               end
            end
         end
         if (req_start && busy === 1'b0) begin
            if (cur_has_typed)
               expected_hashes.push_back(cur_typed_hash);
            else
               expected_hashes.push_back(predict_block_hash(req_opcode, req_leaf_cells,
                  req_child_nw_hash, req_child_ne_hash, req_child_sw_hash,
                  req_child_se_hash, req_child_depth));
            if (req_opcode == OP_LEAF) leaf_count++;
            else node_count++;
         end
         if (rsp_valid || (req_start && busy === 1'b0))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("quadtree_polynomial_hash_top verification failed");
            $finish;
         end
      end
   end

   initial begin
      hash_request_type r;
      logic [63:0]      cpow;
      logic [63:0]      rpow;

      cpow = mul_mod_prime(COL_MUL, COL_MUL);
      rpow = mul_mod_prime(ROW_MUL, ROW_MUL);
      for (int d = 0; d < DEPTHS; d++) begin
         col_pow_by_depth[d] = cpow;
         row_pow_by_depth[d] = rpow;
         cpow = mul_mod_prime(cpow, cpow);
         rpow = mul_mod_prime(rpow, rpow);
      end

      // Every leaf pattern; some rows carry junk in the fields a leaf ignores.
      for (int c = 0; c < 16; c++) begin
         directed_rows[c] = '{OP_LEAF, 4'(c), '0, '0, '0, '0, 8'd0, 1'b0, '0};
         if (c[0]) begin
            directed_rows[c].nw    = HASH_MAX;
            directed_rows[c].ne    = HASH_MAX;
            directed_rows[c].sw    = HASH_MAX;
            directed_rows[c].se    = HASH_MAX;
            directed_rows[c].depth = 8'd255;
         end
      end
      directed_rows[16] = '{OP_NODE, 4'hf, '0, '0, '0, '0, 8'd0, 1'b1, 30'd0};
      directed_rows[17] = '{OP_NODE, 4'h0, 30'd5, '0, '0, '0, 8'd255, 1'b1, 30'd5};
      directed_rows[18] = '{OP_NODE, 4'h0, 30'd1000000007, '0, '0, '0, 8'd17, 1'b1, 30'd0};
      directed_rows[19] = '{OP_NODE, 4'h0, HASH_MAX, '0, '0, '0, 8'd200, 1'b1, 30'd73741816};
      directed_rows[20] = '{OP_NODE, 4'h0, '0, 30'd1, '0, '0, 8'd0, 1'b1, 30'd5433561};
      directed_rows[21] = '{OP_NODE, 4'h0, '0, '0, 30'd1, '0, 8'd0, 1'b0, '0};
      directed_rows[22] = '{OP_NODE, 4'hf, HASH_MAX, HASH_MAX, HASH_MAX, HASH_MAX,
                            8'd255, 1'b0, '0};
      directed_rows[23] = '{OP_NODE, 4'h0, 30'd1000000006, 30'd1000000006, 30'd1000000006,
                            30'd1000000006, 8'd128, 1'b0, '0};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) issue_request(directed_rows[i]);

      for (int n = 0; n < RANDOM_REQS; n++) begin
         r.op    = ($urandom_range(0, 9) < 3) ? OP_LEAF : OP_NODE;
         r.cells = 4'($urandom_range(0, 15));
         r.nw    = random_child_hash();
         r.ne    = random_child_hash();
         r.sw    = random_child_hash();
         r.se    = random_child_hash();
         case ($urandom_range(0, 9))
            0:       r.depth = 8'd0;
            1:       r.depth = 8'd255;
            default: r.depth = 8'($urandom_range(0, 255));
         endcase
         r.has_typed  = 1'b0;
         r.typed_hash = '0;
         issue_request(r);
      end
      req_start <= 1'b0;

      while (expected_hashes.size() != 0) @(posedge clock);
      // Any stray strobe after the last expected hash is caught here.
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Covered %0d requests: %0d leaf patterns and %0d node combines,",
               leaf_count + node_count, leaf_count, node_count);
      $display("with depths 0 to 255 and child hashes above the prime; %0d hashes compared.",
               compared_count);
      if (mismatch_count == 0 && expected_hashes.size() == 0)
         $display("quadtree_polynomial_hash_top verification clean");
      else
         $display("quadtree_polynomial_hash_top verification failed");
      $finish;
   end

endmodule
